FILE: design/spiq_pkg.sv
// Package for the sorted priority insert queue: widths, codes and the
// control struct shared by the cell chain and the sequencer. No dependencies.
`default_nettype none

package spiq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;

    // Input opcodes (only bit 0 is carried)
    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_READOUT = 1'b1
    } opcode_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ENTRY = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;   // take new entry into its sorted slot
        logic rotate;   // move toward front, head wraps to rear
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/spiq_if.sv
// Valid/ready channel interfaces for the sorted priority insert queue.
// Depends on spiq_pkg for the data width.
`default_nettype none

interface spiq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [spiq_pkg::DATA_W-1:0]   value_in;
    logic [spiq_pkg::DATA_W-1:0]   priority_in;

    modport source (output valid, output opcode, output value_in,
                    output priority_in, input ready);
    modport sink   (input valid, input opcode, input value_in,
                    input priority_in, output ready);
endinterface

interface spiq_out_if;
    logic                          valid;
    logic                          ready;
    logic [spiq_pkg::DATA_W-1:0]   value_out;
    logic [1:0]                    status;
    logic                          is_last;

    modport source (output valid, output value_out, output status,
                    output is_last, input ready);
    modport sink   (input valid, input value_out, input status,
                    input is_last, output ready);
endinterface

`default_nettype wire

FILE: design/spiq_cell.sv
// One slot of the sorted queue: value, priority and an occupied flag.
// Depends on spiq_pkg; neighbors are wired by the top level.
`default_nettype none

module spiq_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire spiq_pkg::cell_ctrl_t          ctrl,
    input  wire logic [spiq_pkg::DATA_W-1:0]   new_value,
    input  wire logic [spiq_pkg::DATA_W-1:0]   new_prio,
    input  wire logic                          prev_valid,
    input  wire logic                          prev_shift,
    input  wire logic [spiq_pkg::DATA_W-1:0]   prev_value,
    input  wire logic [spiq_pkg::DATA_W-1:0]   prev_prio,
    input  wire logic                          next_valid,
    input  wire logic [spiq_pkg::DATA_W-1:0]   next_value,
    input  wire logic [spiq_pkg::DATA_W-1:0]   next_prio,
    input  wire logic [spiq_pkg::DATA_W-1:0]   head_value,
    input  wire logic [spiq_pkg::DATA_W-1:0]   head_prio,
    output logic                               valid,
    output logic                               shift,
    output logic [spiq_pkg::DATA_W-1:0]        value,
    output logic [spiq_pkg::DATA_W-1:0]        prio
);
    import spiq_pkg::*;

    logic                valid_reg, valid_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [DATA_W-1:0]   prio_reg,  prio_next;
    logic                take_new;

    // This entry sits at or behind the insertion point
    assign shift    = valid_reg && ($signed(prio_reg) >= $signed(new_prio));
    // Insertion point is here: first shifting cell, or first free cell
    assign take_new = !prev_shift && (shift || (!valid_reg && prev_valid));

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.insert)
        begin
            if (prev_shift)
            begin
                valid_next = 1'b1;
                value_next = prev_value;
                prio_next  = prev_prio;
            end
            else if (take_new)
            begin
                valid_next = 1'b1;
                value_next = new_value;
                prio_next  = new_prio;
            end
        end
        else if (ctrl.rotate)
        begin
            // rear occupied cell receives the head entry
            if (next_valid)
            begin
                value_next = next_value;
                prio_next  = next_prio;
            end
            else if (valid_reg)
            begin
                value_next = head_value;
                prio_next  = head_prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload has no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

`default_nettype wire

FILE: design/spiq_ctrl.sv
// Sequencer and output register of the sorted priority insert queue.
// Depends on spiq_pkg; drives the cell chain command each cycle.
`default_nettype none

module spiq_ctrl #(
    parameter int QUEUE_DEPTH = spiq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_opcode,
    input  wire logic                          full,
    input  wire logic [spiq_pkg::DATA_W-1:0]   head_value,
    output spiq_pkg::cell_ctrl_t               ctrl,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [spiq_pkg::DATA_W-1:0]        value_out,
    output logic [1:0]                         status,
    output logic                               is_last
);
    import spiq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    left_reg,  left_next;
    logic                ovalid_reg, ovalid_next;
    logic [DATA_W-1:0]   value_reg,  value_next;
    status_t             status_reg, status_next;
    logic                last_reg,   last_next;

    logic                slot_free;
    logic                in_go;
    logic                ins_go;
    logic                rd_go;

    assign slot_free = !ovalid_reg || out_ready;
    assign in_go     = in_valid && in_ready;
    assign ins_go    = in_go && (opcode_t'(in_opcode) == OP_INSERT);
    assign rd_go     = in_go && (opcode_t'(in_opcode) == OP_READOUT);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (rd_go && (count_reg != '0))
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (slot_free && (left_reg == CNT_W'(1)))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs, counters and result register
    always_comb
    begin
        in_ready    = 1'b0;
        ctrl        = '0;
        count_next  = count_reg;
        left_next   = left_reg;
        ovalid_next = ovalid_reg && !out_ready;
        value_next  = value_reg;
        status_next = status_reg;
        last_next   = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = slot_free;
                if (ins_go)
                begin
                    if (full)
                    begin
                        ovalid_next = 1'b1;
                        value_next  = '0;
                        status_next = ST_FULL;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                else if (rd_go)
                begin
                    if (count_reg == '0)
                    begin
                        ovalid_next = 1'b1;
                        value_next  = '0;
                        status_next = ST_EMPTY;
                        last_next   = 1'b1;
                    end
                    else
                        left_next = count_reg;
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    ctrl.rotate = 1'b1;
                    ovalid_next = 1'b1;
                    value_next  = head_value;
                    status_next = ST_ENTRY;
                    last_next   = (left_reg == CNT_W'(1));
                    left_next   = left_reg - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            left_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            left_reg   <= left_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid = ovalid_reg;
    assign value_out = value_reg;
    assign status    = status_reg;
    assign is_last   = last_reg;

endmodule

`default_nettype wire

FILE: design/sorted_priority_insert_queue_core.sv
// Top level of the sorted priority insert queue: chain of cells plus sequencer.
// Depends on spiq_pkg, spiq_if, spiq_cell and spiq_ctrl.
//
// Usage:
//   req carries (opcode, value_in, priority_in); rsp carries
//   (value_out, status, is_last). A beat moves when valid and ready are high.
//   Insert: every cell compares its priority with the new one in parallel;
//   the entry lands and the tail shifts back by one. No result,
//   unless the queue is full: then one beat with status full and is_last.
//   Readout: the chain rotates toward the front once per cycle while rsp is
//   not stalled, the head cell feeding the result register, so the entries
//   stream out in order; an empty queue yields one status-empty beat.
//   Throughput: one insert per cycle when rsp is not stalled; a readout
//   keeps req closed until its last entry is out. Rotation and req ready
//   pause while rsp is stalled; the result register holds its beat until taken.
//   Reset clears the occupied flags and the sequencer; stored data is not
//   cleared and never read before it is written.
`default_nettype none

module sorted_priority_insert_queue_core #(
    parameter int QUEUE_DEPTH = spiq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    spiq_in_if.sink     req,
    spiq_out_if.source  rsp
);
    import spiq_pkg::*;

    cell_ctrl_t          ctrl;
    logic                c_valid [QUEUE_DEPTH];
    logic                c_shift [QUEUE_DEPTH];
    logic [DATA_W-1:0]   c_value [QUEUE_DEPTH];
    logic [DATA_W-1:0]   c_prio  [QUEUE_DEPTH];

    // Cell chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                p_valid, p_shift, n_valid;
        logic [DATA_W-1:0]   p_value, p_prio, n_value, n_prio;

        if (i == 0)
        begin : g_front
            assign p_valid = 1'b1;
            assign p_shift = 1'b0;
            assign p_value = '0;
            assign p_prio  = '0;
        end
        else
        begin : g_mid
            assign p_valid = c_valid[i-1];
            assign p_shift = c_shift[i-1];
            assign p_value = c_value[i-1];
            assign p_prio  = c_prio[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_rear
            assign n_valid = 1'b0;
            assign n_value = '0;
            assign n_prio  = '0;
        end
        else
        begin : g_inner
            assign n_valid = c_valid[i+1];
            assign n_value = c_value[i+1];
            assign n_prio  = c_prio[i+1];
        end

        spiq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_value  (req.value_in),
            .new_prio   (req.priority_in),
            .prev_valid (p_valid),
            .prev_shift (p_shift),
            .prev_value (p_value),
            .prev_prio  (p_prio),
            .next_valid (n_valid),
            .next_value (n_value),
            .next_prio  (n_prio),
            .head_value (c_value[0]),
            .head_prio  (c_prio[0]),
            .valid      (c_valid[i]),
            .shift      (c_shift[i]),
            .value      (c_value[i]),
            .prio       (c_prio[i])
        );
    end

    // Sequencer and result register
    spiq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_opcode  (req.opcode),
        .full       (c_valid[QUEUE_DEPTH-1]),
        .head_value (c_value[0]),
        .ctrl       (ctrl),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .value_out  (rsp.value_out),
        .status     (rsp.status),
        .is_last    (rsp.is_last)
    );

endmodule

`default_nettype wire

FILE: design/spiq_checker.sv
// Port-level checks for the sorted priority insert queue, bound to the top.
// Depends on spiq_pkg for status codes.
`default_nettype none

module spiq_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_ready,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    input  wire logic [spiq_pkg::DATA_W-1:0]   rsp_value_out,
    input  wire logic [1:0]                    rsp_status,
    input  wire logic                          rsp_is_last
);
    import spiq_pkg::*;

    // status beats are single and final, carrying zero
    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_FULL)
        |-> rsp_is_last && (rsp_value_out == '0))
        else $error("status beat not final or nonzero");

    // no unused status code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_ENTRY || rsp_status == ST_EMPTY
        || rsp_status == ST_FULL))
        else $error("illegal status code");

    // mid-readout the request side stays closed
    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_is_last |-> !req_ready)
        else $error("request accepted during readout");

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out)
        && $stable(rsp_status) && $stable(rsp_is_last))
        else $error("stalled result changed");

endmodule

bind sorted_priority_insert_queue_core spiq_checker u_spiq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_value_out (rsp.value_out),
    .rsp_status    (rsp.status),
    .rsp_is_last   (rsp.is_last)
);

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for sorted_priority_insert_queue_core: directed table, then random beats.
// Depends on spiq_pkg and spiq_if from the design folder, and on the core itself.
`timescale 1ns / 100ps

module tb;

    import spiq_pkg::*;

    localparam int QD         = QUEUE_DEPTH_DEF;
    localparam int NUM_ROWS   = 21;
    localparam int NUM_RANDOM = 250;
    localparam int LONG_HOLD  = 300;
    localparam int CYCLE_CAP  = 400000;

    // One expected result beat
    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
        logic              is_last;
    } rsp_beat_t;

    // One directed stimulus row; typed rows carry their single status beat
    typedef struct packed {
        opcode_t           op;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] prio;
        logic              typed;
        status_t           typed_status;
    } stim_row_t;

    // Empty readout, extremes, equal priorities, fill to full, drops, readouts
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        '{OP_READOUT, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_INSERT,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h8000_0000, 32'h7FFF_FFFF, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'hFFFF_FFFF, 32'h8000_0000, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_0005, 32'h0000_0000, 1'b0, ST_ENTRY},
        '{OP_READOUT, 32'h0000_0000, 32'h0000_0000, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_0000, 32'h0000_0000, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_0006, 32'h7FFF_FFFF, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_0007, 32'hFFFF_FFFB, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_0008, 32'h0000_0064, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_0009, 32'hFFFF_FF9C, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_000A, 32'h8000_0000, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_000B, 32'h0000_0032, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_000C, 32'h0000_0001, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_000D, 32'hFFFF_FFFF, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_000E, 32'h7FFF_FFFE, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_000F, 32'h8000_0001, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'h0000_0010, 32'h0000_0000, 1'b0, ST_ENTRY},
        '{OP_INSERT,  32'hAAAA_AAAA, 32'h5555_5555, 1'b1, ST_FULL},
        '{OP_INSERT,  32'h8000_0000, 32'h8000_0000, 1'b1, ST_FULL},
        '{OP_READOUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ST_ENTRY}
    };

    logic clk;
    logic rst_n;

    spiq_in_if  req_if ();
    spiq_out_if rsp_if ();

    sorted_priority_insert_queue_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the sorted queue
    logic [DATA_W-1:0] held_value [QD];
    logic [DATA_W-1:0] held_prio  [QD];
    int                held_count;

    rsp_beat_t expected_beats [$];
    int        mismatches;
    int        cycle_count;
    int        burst_left;
    bit        hold_request;

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run-time cap
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Work out the result beats of one accepted request beat
    task automatic predict_queue_op(input opcode_t op, input logic [DATA_W-1:0] val,
                                    input logic [DATA_W-1:0] pri);
        int        slot;
        int        i;
        rsp_beat_t beat;
        if (op == OP_INSERT)
        begin
            if (held_count >= QD)
            begin
                beat.value   = '0;
                beat.status  = ST_FULL;
                beat.is_last = 1'b1;
                expected_beats.push_back(beat);
            end
            else
            begin
                // first entry whose priority is >= the new one, else the rear
                slot = held_count;
                for (i = held_count - 1; i >= 0; i--)
                    if ($signed(held_prio[i]) >= $signed(pri))
                        slot = i;
                for (i = held_count; i > slot; i--)
                begin
                    held_value[i] = held_value[i - 1];
                    held_prio[i]  = held_prio[i - 1];
                end
                held_value[slot] = val;
                held_prio[slot]  = pri;
                held_count++;
            end
        end
        else if (held_count == 0)
        begin
            beat.value   = '0;
            beat.status  = ST_EMPTY;
            beat.is_last = 1'b1;
            expected_beats.push_back(beat);
        end
        else
        begin
            for (i = 0; i < held_count; i++)
            begin
                beat.value   = held_value[i];
                beat.status  = ST_ENTRY;
                beat.is_last = (i == held_count - 1);
                expected_beats.push_back(beat);
            end
        end
    endtask

    // Offer one request beat, wait for acceptance, then record what it should give
    task automatic send_beat(input opcode_t op, input logic [DATA_W-1:0] val,
                             input logic [DATA_W-1:0] pri, input logic typed,
                             input status_t typed_status);
        int        n0;
        rsp_beat_t beat;
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.value_in    <= val;
        req_if.priority_in <= pri;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        n0 = expected_beats.size();
        predict_queue_op(op, val, pri);
        if (typed)
        begin
            // typed rows replace the predicted beat with the status beat given in the table
            while (expected_beats.size() > n0)
                void'(expected_beats.pop_back());
            beat.value   = '0;
            beat.status  = typed_status;
            beat.is_last = 1'b1;
            expected_beats.push_back(beat);
        end
    endtask

    // Bursts of random length separated by random gaps
    task automatic sender_gap();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Request side: reset, directed table, random beats, drain
    initial
    begin : stimulus
        opcode_t           op;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] pri;
        int                k;
        mismatches   = 0;
        held_count   = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.opcode      <= OP_INSERT;
        req_if.value_in    <= '0;
        req_if.priority_in <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < NUM_ROWS; k++)
        begin
            send_beat(DIRECTED[k].op, DIRECTED[k].value, DIRECTED[k].prio,
                      DIRECTED[k].typed, DIRECTED[k].typed_status);
            sender_gap();
        end

        for (k = 0; k < NUM_RANDOM; k++)
        begin
            // long receiver hold while readouts keep coming
            if (k == 60)
                hold_request = 1'b1;
            // let everything drain once
            if (k == 180)
            begin
                req_if.valid <= 1'b0;
                @(posedge clk);
                while (expected_beats.size() != 0)
                    @(posedge clk);
            end
            op = ($urandom_range(0, 3) == 0) ? OP_READOUT : OP_INSERT;
            val = $urandom;
            case ($urandom_range(0, 3))
                0:       pri = 32'h8000_0000;
                1:       pri = 32'h7FFF_FFFF;
                2:       pri = $urandom_range(0, 4) - 2;
                default: pri = $urandom;
            endcase
            send_beat(op, val, pri, 1'b0, ST_ENTRY);
            sender_gap();
        end

        // drain, then watch for stray beats
        req_if.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result side: stall pattern of its own plus one long hold
    initial
    begin : receiver
        int   hold_left;
        int   run_left;
        int   run_mode;
        bit   hold_done;
        logic rdy;
        hold_left = 0;
        run_left  = 0;
        run_mode  = 0;
        hold_done = 1'b0;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_mode = $urandom_range(0, 3);
                    run_left = $urandom_range(4, 40);
                end
                run_left--;
                case (run_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = 1'($urandom_range(0, 1));
                    default: rdy = ($urandom_range(0, 4) == 0);
                endcase
            end
            rsp_if.ready <= rdy;
            @(posedge clk);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : check_results
        rsp_beat_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: value_out %0d status %0d is_last %0d",
                       $signed(rsp_if.value_out), rsp_if.status, rsp_if.is_last);
                mismatches++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (rsp_if.value_out !== want.value)
                begin
                    $error("value_out: expected %0d, got %0d",
                           $signed(want.value), $signed(rsp_if.value_out));
                    mismatches++;
                end
                if (rsp_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    mismatches++;
                end
                if (rsp_if.is_last !== want.is_last)
                begin
                    $error("is_last: expected %0d, got %0d", want.is_last, rsp_if.is_last);
                    mismatches++;
                end
            end
        end
    end

endmodule
